// File: rtl/core/tpld_pkg.sv
// tpld_pkg: shared types, sizes and codes for the two-partition LRU directory.
// Used by tpld_store and two_partition_lru_directory_unit. No dependencies.
package tpld_pkg;

    localparam int PART_DEPTH = 16;
    localparam int PART_AW    = (PART_DEPTH > 1) ? $clog2(PART_DEPTH) : 1;
    localparam int CNT_W      = $clog2(PART_DEPTH + 1);
    localparam int MEM_AW     = PART_AW + 1;
    localparam int MEM_DEPTH  = 2 * PART_DEPTH;
    localparam int KEY_W      = 64;
    localparam int HANDLE_W   = 32;
    localparam int REQ_W      = 2;
    localparam int CAP_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_CAP  = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MOVE,
        ST_FINAL,
        ST_DONE
    } state_t;

    // what the final step does after the shift
    typedef enum logic [1:0] {
        FIN_FRONT,
        FIN_INSERT,
        FIN_DELETE
    } fin_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic              re;
        logic [MEM_AW-1:0] raddr;
        logic              we;
        logic [MEM_AW-1:0] waddr;
    } mem_ctrl_t;

    // register value 0 acts as 1, above the depth acts as the depth
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] wide;
        begin
            wide = CMP_W'(cap);
            if (cap == '0)
                return CNT_W'(1);
            if (wide > CMP_W'(PART_DEPTH))
                return CNT_W'(PART_DEPTH);
            return CNT_W'(cap);
        end
    endfunction

endpackage

// File: rtl/core/tpld_store.sv
// tpld_store: entry memory for both partitions (address = partition, position),
// registered read port, one write port and the shared key comparator. Uses tpld_pkg.
module tpld_store
    import tpld_pkg::*;
(
    input  logic             clk,
    input  mem_ctrl_t        ctrl,
    input  entry_t           wdata,
    input  logic [KEY_W-1:0] cmp_key,
    output entry_t           rdata,
    output logic             key_match
);

    entry_t mem [MEM_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[ctrl.waddr] <= wdata;
        end
        if (ctrl.re)
        begin
            rdata_reg <= mem[ctrl.raddr];
        end
    end

    assign rdata     = rdata_reg;
    assign key_match = (rdata_reg.key == cmp_key);

endmodule

// File: rtl/core/two_partition_lru_directory_unit.sv
// two_partition_lru_directory_unit: top level, request sequencer and config registers.
// Depends on tpld_pkg and tpld_store.
// Sequence: accept, scan of the partition (a lookup may scan both), shift of the entries,
//   final step (front write or count update), result load.
// Throughput: one request at a time; result load waits while the output beat is stalled.
// Reset: counts zero, both capacities 16, entry memory contents not cleared.
module two_partition_lru_directory_unit
    import tpld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [KEY_W-1:0]     key,
    input  logic                 is_data,
    input  logic [HANDLE_W-1:0]  node_handle,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic                 found_in_data,
    output logic [HANDLE_W-1:0]  handle_out,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAP_W-1:0]     cfg_data
);

    state_t state_reg, state_next;
    fin_t   fin_reg, fin_next;

    logic [CAP_W-1:0]    idx_cap_reg, dat_cap_reg;
    logic [CNT_W-1:0]    idx_cnt_reg, idx_cnt_next;
    logic [CNT_W-1:0]    dat_cnt_reg, dat_cnt_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic                part_reg, part_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                rvalid_reg, rvalid_next;
    logic [CNT_W-1:0]    mv_left_reg, mv_left_next;
    logic                wpend_reg, wpend_next;
    logic                dir_up_reg, dir_up_next;
    logic                out_valid_reg, out_valid_next;

    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [HANDLE_W-1:0] front_handle_reg, front_handle_next;
    logic [PART_AW-1:0]  src_reg, src_next;
    logic [PART_AW-1:0]  wdst_reg, wdst_next;
    logic                res_hit_reg, res_hit_next;
    logic                res_data_reg, res_data_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                hit_reg, hit_next;
    logic                fid_reg, fid_next;
    logic [HANDLE_W-1:0] hout_reg, hout_next;

    mem_ctrl_t           mem_ctrl;
    entry_t              mem_wdata;
    entry_t              mem_rdata;
    logic                key_match;

    logic [CNT_W-1:0]    cur_cnt;
    logic [CNT_W-1:0]    cur_cap;
    logic [CNT_W-1:0]    new_cnt;
    logic                cnt_we;
    logic [PART_AW-1:0]  pos_found;
    logic [CNT_W-1:0]    ins_top;

    tpld_store u_store (
        .clk       (clk),
        .ctrl      (mem_ctrl),
        .wdata     (mem_wdata),
        .cmp_key   (key_reg),
        .rdata     (mem_rdata),
        .key_match (key_match)
    );

    assign in_stall      = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign found_in_data = fid_reg;
    assign handle_out    = hout_reg;

    assign cur_cnt   = part_reg ? dat_cnt_reg : idx_cnt_reg;
    assign cur_cap   = eff_cap(part_reg ? dat_cap_reg : idx_cap_reg);
    assign pos_found = PART_AW'(ptr_reg - CNT_W'(1));
    // a full partition shifts its last entry out
    assign ins_top   = (cur_cnt < CNT_W'(PART_DEPTH)) ? cur_cnt : CNT_W'(PART_DEPTH - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_cap_reg <= CAP_RESET;
            dat_cap_reg <= CAP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_INDEX_CAP: idx_cap_reg <= cfg_data;
                CFG_DATA_CAP:  dat_cap_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fin_reg       <= FIN_FRONT;
            idx_cnt_reg   <= '0;
            dat_cnt_reg   <= '0;
            req_reg       <= REQ_LOOKUP;
            part_reg      <= 1'b0;
            ptr_reg       <= '0;
            rvalid_reg    <= 1'b0;
            mv_left_reg   <= '0;
            wpend_reg     <= 1'b0;
            dir_up_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            idx_cnt_reg   <= idx_cnt_next;
            dat_cnt_reg   <= dat_cnt_next;
            req_reg       <= req_next;
            part_reg      <= part_next;
            ptr_reg       <= ptr_next;
            rvalid_reg    <= rvalid_next;
            mv_left_reg   <= mv_left_next;
            wpend_reg     <= wpend_next;
            dir_up_reg    <= dir_up_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg          <= key_next;
        handle_reg       <= handle_next;
        front_handle_reg <= front_handle_next;
        src_reg          <= src_next;
        wdst_reg         <= wdst_next;
        res_hit_reg      <= res_hit_next;
        res_data_reg     <= res_data_next;
        res_handle_reg   <= res_handle_next;
        hit_reg          <= hit_next;
        fid_reg          <= fid_next;
        hout_reg         <= hout_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        fin_next          = fin_reg;
        req_next          = req_reg;
        part_next         = part_reg;
        ptr_next          = ptr_reg;
        rvalid_next       = rvalid_reg;
        mv_left_next      = mv_left_reg;
        wpend_next        = wpend_reg;
        dir_up_next       = dir_up_reg;
        key_next          = key_reg;
        handle_next       = handle_reg;
        front_handle_next = front_handle_reg;
        src_next          = src_reg;
        wdst_next         = wdst_reg;
        res_hit_next      = res_hit_reg;
        res_data_next     = res_data_reg;
        res_handle_next   = res_handle_reg;
        hit_next          = hit_reg;
        fid_next          = fid_reg;
        hout_next         = hout_reg;
        mem_ctrl          = '0;
        mem_wdata         = '{key: key_reg, handle: front_handle_reg};
        cnt_we            = 1'b0;
        new_cnt           = cur_cnt;

        // output register frees up when its beat is taken
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = req_type;
                    key_next        = key;
                    handle_next     = node_handle;
                    part_next       = (req_type == REQ_LOOKUP) ? 1'b0 : is_data;
                    ptr_next        = '0;
                    rvalid_next     = 1'b0;
                    res_hit_next    = 1'b0;
                    res_data_next   = 1'b0;
                    res_handle_next = '0;
                    if (req_type == REQ_LOOKUP || req_type == REQ_ADD
                        || req_type == REQ_REMOVE)
                        state_next = ST_SEARCH;
                    else
                        state_next = ST_DONE;
                end
            end

            ST_SEARCH:
            begin
                rvalid_next = 1'b0;
                if (rvalid_reg && key_match)
                begin
                    res_hit_next    = 1'b1;
                    res_data_next   = part_reg;
                    res_handle_next = mem_rdata.handle;
                    state_next      = ST_MOVE;
                    wpend_next      = 1'b0;
                    if (req_reg == REQ_REMOVE)
                    begin
                        fin_next     = FIN_DELETE;
                        dir_up_next  = 1'b1;
                        src_next     = pos_found + PART_AW'(1);
                        mv_left_next = cur_cnt - CNT_W'(1) - CNT_W'(pos_found);
                    end
                    else
                    begin
                        fin_next          = FIN_FRONT;
                        dir_up_next       = 1'b0;
                        src_next          = pos_found - PART_AW'(1);
                        mv_left_next      = CNT_W'(pos_found);
                        front_handle_next = (req_reg == REQ_LOOKUP) ? mem_rdata.handle
                                                                    : handle_reg;
                    end
                end
                else if (ptr_reg < cur_cnt)
                begin
                    mem_ctrl.re    = 1'b1;
                    mem_ctrl.raddr = {part_reg, ptr_reg[PART_AW-1:0]};
                    ptr_next       = ptr_reg + CNT_W'(1);
                    rvalid_next    = 1'b1;
                end
                else if (req_reg == REQ_LOOKUP && !part_reg)
                begin
                    // index partition missed, try data partition
                    part_next = 1'b1;
                    ptr_next  = '0;
                end
                else if (req_reg == REQ_ADD)
                begin
                    fin_next          = FIN_INSERT;
                    dir_up_next       = 1'b0;
                    src_next          = ins_top[PART_AW-1:0] - PART_AW'(1);
                    mv_left_next      = ins_top;
                    front_handle_next = handle_reg;
                    wpend_next        = 1'b0;
                    state_next        = ST_MOVE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_MOVE:
            begin
                wpend_next = 1'b0;
                if (wpend_reg)
                begin
                    mem_ctrl.we    = 1'b1;
                    mem_ctrl.waddr = {part_reg, wdst_reg};
                    mem_wdata      = mem_rdata;
                end
                if (mv_left_reg != '0)
                begin
                    mem_ctrl.re    = 1'b1;
                    mem_ctrl.raddr = {part_reg, src_reg};
                    wdst_next      = dir_up_reg ? src_reg - PART_AW'(1)
                                                : src_reg + PART_AW'(1);
                    src_next       = dir_up_reg ? src_reg + PART_AW'(1)
                                                : src_reg - PART_AW'(1);
                    mv_left_next   = mv_left_reg - CNT_W'(1);
                    wpend_next     = 1'b1;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                unique case (fin_reg)
                    FIN_FRONT:
                    begin
                        mem_ctrl.we    = 1'b1;
                        mem_ctrl.waddr = {part_reg, PART_AW'(0)};
                    end
                    FIN_INSERT:
                    begin
                        mem_ctrl.we    = 1'b1;
                        mem_ctrl.waddr = {part_reg, PART_AW'(0)};
                        cnt_we         = 1'b1;
                        if (cur_cnt < CNT_W'(PART_DEPTH) && cur_cnt < cur_cap)
                            new_cnt = cur_cnt + CNT_W'(1);
                    end
                    FIN_DELETE:
                    begin
                        cnt_we  = 1'b1;
                        new_cnt = cur_cnt - CNT_W'(1);
                    end
                    default: ;
                endcase
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    fid_next       = res_data_reg;
                    hout_next      = res_handle_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        idx_cnt_next = (cnt_we && !part_reg) ? new_cnt : idx_cnt_reg;
        dat_cnt_next = (cnt_we && part_reg) ? new_cnt : dat_cnt_reg;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for two_partition_lru_directory_unit.
// Holds its own model of both LRU partitions; depends on tpld_pkg and the unit RTL.
module testbench;
    import tpld_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int IDX_PART       = 0;
    localparam int DAT_PART       = 1;
    localparam int RESET_CYCLES   = 12;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 60;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 2 * PART_DEPTH + 16;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_PRINTS     = 40;
    localparam int POOL_SIZE      = 32;

    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [KEY_W-1:0]    key;
        logic                is_data;
        logic [HANDLE_W-1:0] handle;
    } dir_req_t;

    typedef struct packed {
        logic                hit;
        logic                in_data;
        logic [HANDLE_W-1:0] handle;
    } dir_rsp_t;

    typedef struct packed {
        dir_req_t req;
        logic     typed;
        dir_rsp_t rsp;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [REQ_W-1:0]     req_type = '0;
    logic [KEY_W-1:0]     key = '0;
    logic                 is_data = 1'b0;
    logic [HANDLE_W-1:0]  node_handle = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 hit;
    logic                 found_in_data;
    logic [HANDLE_W-1:0]  handle_out;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_INDEX_CAP;
    logic [CAP_W-1:0]     cfg_data = '0;

    // directory model: position 0 is most recent
    logic [KEY_W-1:0]    part_keys    [2][PART_DEPTH];
    logic [HANDLE_W-1:0] part_handles [2][PART_DEPTH];
    int                  part_count   [2];
    logic [CAP_W-1:0]    cap_reg      [2];

    dir_rsp_t         expected_rsp [$];
    dir_row_t         dir_rows [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_off = 1'b0;
    int mismatch_count = 0;
    int req_count = 0;
    int rsp_count = 0;
    int hit_count = 0;
    int settings_count = 0;
    int cycle_count = 0;

    two_partition_lru_directory_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .key           (key),
        .is_data       (is_data),
        .node_handle   (node_handle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .found_in_data (found_in_data),
        .handle_out    (handle_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("two_partition_lru_directory_unit test failed");
            $finish;
        end
    end

    // ---------------- model of the directory ----------------

    function automatic int slots_allowed(input logic [CAP_W-1:0] r);
        if (r == '0)
            return 1;
        if (int'(r) > PART_DEPTH)
            return PART_DEPTH;
        return int'(r);
    endfunction

    function automatic int locate(input int p, input logic [KEY_W-1:0] k);
        for (int i = 0; i < part_count[p]; i++)
            if (part_keys[p][i] == k)
                return i;
        return -1;
    endfunction

    function automatic void promote(input int p, input int pos);
        logic [KEY_W-1:0]    k;
        logic [HANDLE_W-1:0] h;
        k = part_keys[p][pos];
        h = part_handles[p][pos];
        for (int i = pos; i > 0; i--)
        begin
            part_keys[p][i]    = part_keys[p][i-1];
            part_handles[p][i] = part_handles[p][i-1];
        end
        part_keys[p][0]    = k;
        part_handles[p][0] = h;
    endfunction

    function automatic void evict_at(input int p, input int pos);
        for (int i = pos; i + 1 < part_count[p]; i++)
        begin
            part_keys[p][i]    = part_keys[p][i+1];
            part_handles[p][i] = part_handles[p][i+1];
        end
        part_count[p]--;
    endfunction

    // new key at the front; a full store loses its tail, over-capacity drops one
    function automatic void push_front(input int p, input logic [KEY_W-1:0] k,
                                       input logic [HANDLE_W-1:0] h);
        int n;
        int top;
        n   = part_count[p];
        top = (n < PART_DEPTH) ? n : PART_DEPTH - 1;
        for (int i = top; i > 0; i--)
        begin
            part_keys[p][i]    = part_keys[p][i-1];
            part_handles[p][i] = part_handles[p][i-1];
        end
        part_keys[p][0]    = k;
        part_handles[p][0] = h;
        if (n < PART_DEPTH)
        begin
            n++;
            if (n > slots_allowed(cap_reg[p]))
                n--;
        end
        part_count[p] = n;
    endfunction

    function automatic dir_rsp_t directory_step(input dir_req_t r);
        dir_rsp_t o;
        int       p;
        int       pos;
        o = '0;
        p = r.is_data ? DAT_PART : IDX_PART;
        case (r.req)
            REQ_LOOKUP:
            begin
                pos = locate(IDX_PART, r.key);
                if (pos >= 0)
                begin
                    promote(IDX_PART, pos);
                    o.hit    = 1'b1;
                    o.handle = part_handles[IDX_PART][0];
                end
                else
                begin
                    pos = locate(DAT_PART, r.key);
                    if (pos >= 0)
                    begin
                        promote(DAT_PART, pos);
                        o.hit     = 1'b1;
                        o.in_data = 1'b1;
                        o.handle  = part_handles[DAT_PART][0];
                    end
                end
            end
            REQ_ADD:
            begin
                pos = locate(p, r.key);
                if (pos >= 0)
                begin
                    // refresh: report the old handle, keep the new one
                    promote(p, pos);
                    o.hit     = 1'b1;
                    o.in_data = r.is_data;
                    o.handle  = part_handles[p][0];
                    part_handles[p][0] = r.handle;
                end
                else
                    push_front(p, r.key, r.handle);
            end
            REQ_REMOVE:
            begin
                pos = locate(p, r.key);
                if (pos >= 0)
                begin
                    o.hit     = 1'b1;
                    o.in_data = r.is_data;
                    o.handle  = part_handles[p][pos];
                    evict_at(p, pos);
                end
            end
            default:
            begin
            end
        endcase
        if (o.hit)
            hit_count++;
        return o;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic dir_req_t random_request(input int span);
        dir_req_t r;
        int       roll;
        roll = $urandom_range(99);
        if (roll < 40)
            r.req = REQ_LOOKUP;
        else if (roll < 75)
            r.req = REQ_ADD;
        else if (roll < 95)
            r.req = REQ_REMOVE;
        else
            r.req = REQ_UNUSED;
        if ($urandom_range(99) < 90)
            r.key = key_pool[$urandom_range(span)];
        else
            r.key = {$urandom, $urandom};
        r.is_data = 1'($urandom_range(1));
        r.handle  = $urandom;
        return r;
    endfunction

    task automatic add_row(input logic [REQ_W-1:0] rq, input logic [KEY_W-1:0] k,
                           input logic d, input logic [HANDLE_W-1:0] h, input logic typed,
                           input logic e_hit, input logic e_data,
                           input logic [HANDLE_W-1:0] e_handle);
        dir_row_t row;
        row.req   = '{req: rq, key: k, is_data: d, handle: h};
        row.typed = typed;
        row.rsp   = '{hit: e_hit, in_data: e_data, handle: e_handle};
        dir_rows.push_back(row);
    endtask

    task automatic issue_request(input dir_req_t r, input logic typed,
                                 input dir_rsp_t typed_rsp);
        dir_rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= r.req;
        key         <= r.key;
        is_data     <= r.is_data;
        node_handle <= r.handle;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = directory_step(r);
        expected_rsp.push_back(typed ? typed_rsp : predicted);
        req_count++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacities(input logic [CAP_W-1:0] icap,
                                    input logic [CAP_W-1:0] dcap);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INDEX_CAP;
        cfg_data  <= icap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_reg[IDX_PART] = icap;
        cfg_index <= CFG_DATA_CAP;
        cfg_data  <= dcap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_reg[DAT_PART] = dcap;
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        // keep the log short on a badly broken build; every miss is still counted
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch at %0t, result beat %0d: %s got %0h want %0h",
                     $time, rsp_count, what, got, want);
        mismatch_count++;
    endtask

    // ---------------- result side ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin : hold_off_proc
        int n;
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : rsp_check
        dir_rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("result with nothing pending, handle",
                                KEY_W'(handle_out), '0);
            else
            begin
                want = expected_rsp.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", KEY_W'(hit), KEY_W'(want.hit));
                if (found_in_data !== want.in_data)
                    report_mismatch("found_in_data", KEY_W'(found_in_data),
                                    KEY_W'(want.in_data));
                if (handle_out !== want.handle)
                    report_mismatch("handle_out", KEY_W'(handle_out), KEY_W'(want.handle));
            end
            rsp_count++;
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin : stimulus
        dir_rsp_t         none;
        int               ph;
        int               n;
        int               span;
        logic [CAP_W-1:0] icap;
        logic [CAP_W-1:0] dcap;
        none = '0;
        part_count[IDX_PART] = 0;
        part_count[DAT_PART] = 0;
        cap_reg[IDX_PART]    = CAP_RESET;
        cap_reg[DAT_PART]    = CAP_RESET;

        // upper half of the pool differs from the lower half in a single bit
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < POOL_SIZE / 2; n++)
            key_pool[n] = {$urandom, $urandom};
        for (n = POOL_SIZE / 2; n < POOL_SIZE; n++)
            key_pool[n] = key_pool[n - POOL_SIZE / 2] ^ (64'h1 << $urandom_range(63));

        // expected values typed in only where obvious
        add_row(REQ_LOOKUP, '0, 1'b0, '0, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_ADD, '0, 1'b0, '0, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_ADD, '1, 1'b0, '1, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_LOOKUP, '1, 1'b1, '0, 1'b1, 1'b1, 1'b0, 32'hffff_ffff);
        add_row(REQ_ADD, '1, 1'b0, 32'h1234_5678, 1'b1, 1'b1, 1'b0, 32'hffff_ffff);
        add_row(REQ_ADD, '1, 1'b1, 32'ha5a5_a5a5, 1'b1, 1'b0, 1'b0, '0);
        // same key in both partitions: index side answers
        add_row(REQ_LOOKUP, '1, 1'b0, '0, 1'b1, 1'b1, 1'b0, 32'h1234_5678);
        add_row(REQ_REMOVE, '1, 1'b0, '0, 1'b1, 1'b1, 1'b0, 32'h1234_5678);
        add_row(REQ_LOOKUP, '1, 1'b0, '0, 1'b1, 1'b1, 1'b1, 32'ha5a5_a5a5);
        add_row(REQ_REMOVE, '1, 1'b0, '0, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_UNUSED, '1, 1'b1, '1, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_LOOKUP, '0, 1'b0, '0, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_ADD, '0, 1'b1, 32'h5a5a_5a5a, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_REMOVE, '1, 1'b1, '0, 1'b1, 1'b1, 1'b1, 32'ha5a5_a5a5);
        add_row(REQ_REMOVE, '1, 1'b1, '0, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_LOOKUP, '1, 1'b0, '0, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_ADD, 64'h8000_0000_0000_0001, 1'b0, 32'h8000_0001, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_LOOKUP, 64'h0000_0000_0000_0001, 1'b0, '0, 1'b1, 1'b0, 1'b0, '0);
        add_row(REQ_LOOKUP, 64'h8000_0000_0000_0001, 1'b0, '0, 1'b1, 1'b1, 1'b0,
                32'h8000_0001);
        add_row(REQ_REMOVE, '0, 1'b1, '0, 1'b1, 1'b1, 1'b1, 32'h5a5a_5a5a);
        add_row(REQ_LOOKUP, '0, 1'b1, '0, 1'b1, 1'b1, 1'b0, '0);
        add_row(REQ_ADD, 64'h0123_4567_89ab_cdef, 1'b1, 32'hdead_beef, 1'b0, 1'b0, 1'b0, '0);
        add_row(REQ_ADD, 64'h0123_4567_89ab_cdef, 1'b1, 32'h0bad_f00d, 1'b0, 1'b0, 1'b0, '0);
        add_row(REQ_LOOKUP, 64'h0123_4567_89ab_cdef, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0);
        add_row(REQ_REMOVE, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0);

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        settle();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin icap = 5'd16; dcap = 5'd16; span = 31; end
                1: begin icap = 5'd0;  dcap = 5'd31; span = 7;  end
                2: begin icap = 5'd1;  dcap = 5'd1;  span = 5;  end
                3: begin icap = 5'd31; dcap = 5'd0;  span = 31; end
                4: begin icap = 5'd4;  dcap = 5'd9;  span = 15; end
                5: begin icap = 5'd17; dcap = 5'd16; span = 31; end
                // drop well below the counts left by the phase before
                6: begin icap = 5'd2;  dcap = 5'd3;  span = 31; end
                default:
                begin
                    icap = CAP_W'($urandom_range(31));
                    dcap = CAP_W'($urandom_range(31));
                    span = 31;
                end
            endcase
            write_capacities(icap, dcap);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (ph == PRESSURE_PHASE)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                issue_request(random_request(span), 1'b0, none);
            settle();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (expected_rsp.size() != 0)
            report_mismatch("results never delivered", KEY_W'(expected_rsp.size()), '0);

        $display("%0d requests sent, %0d results checked, %0d of them hits",
                 req_count, rsp_count, hit_count);
        $display("%0d capacity settings, idle and stall mixes, one long output hold-off",
                 settings_count);
        if (mismatch_count == 0)
            $display("two_partition_lru_directory_unit test passed");
        else
            $display("two_partition_lru_directory_unit test failed");
        $finish;
    end

endmodule

// File: two_partition_lru_directory_unit.f
rtl/core/tpld_pkg.sv
rtl/core/tpld_store.sv
rtl/core/two_partition_lru_directory_unit.sv
tb/testbench.sv
